### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while rst_n is low. Synthesis
// builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### sv/rrcp_pkg.sv
// ----------------------------------------------------------------------------
// rrcp_pkg
// Shared types and constants of the ring reserve/commit pointer manager.
// ----------------------------------------------------------------------------
package rrcp_pkg;

  // Ring size in bytes. It must be a power of two: offsets wrap by
  // truncation to OFF_W bits.
  localparam int RING_BYTES = 4096;
  localparam int OFF_W      = (RING_BYTES > 2) ? $clog2(RING_BYTES) : 1;

  // Width of the length, offset and span fields on the ports.
  localparam int FIELD_W = 12;

  // Compare width that holds both an offset and a field without loss.
  localparam int WIDE_W = ((OFF_W > FIELD_W) ? OFF_W : FIELD_W) + 1;

  typedef logic [OFF_W-1:0]   off_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [WIDE_W-1:0]  wide_t;

  // Operation codes carried in tuser.
  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CONSUME = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } rrcp_cmd_t;

  // Low field bits of a ring offset, zero extended for small rings.
  function automatic field_t off_to_field(off_t value);
    wide_t wide;
    wide = WIDE_W'(value);
    return wide[FIELD_W-1:0];
  endfunction

endpackage

### sv/rrcp_ctrl.sv
// ----------------------------------------------------------------------------
// rrcp_ctrl
// Handshake controller: tracks whether the result register holds a beat and
// tells the datapath when to execute an accepted operation.
// ----------------------------------------------------------------------------
module rrcp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rrcp_pkg::rrcp_cmd_t cmd
);
  import rrcp_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   exec;

  // A new beat is taken when the result register is free or being drained.
  assign in_tready  = (state_r == ST_EMPTY) || out_tready;
  assign out_tvalid = (state_r == ST_FULL);
  assign exec       = in_tvalid && in_tready;
  assign cmd.exec   = exec;

  // Next state of the result register occupancy.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (exec) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (exec) begin
          state_nxt = ST_FULL;
        end else if (out_tready) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/rrcp_datapath.sv
// ----------------------------------------------------------------------------
// rrcp_datapath
// Read head, reserve tail and commit tail registers, the acquire, release and
// consume checks, and the registered result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrcp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  rrcp_pkg::rrcp_cmd_t cmd,
  input  rrcp_pkg::kind_t     in_kind,
  input  rrcp_pkg::field_t    in_length,
  input  rrcp_pkg::field_t    in_start_offset,
  output logic                out_ok,
  output rrcp_pkg::field_t    out_grant_offset,
  output rrcp_pkg::field_t    out_span_length
);
  import rrcp_pkg::*;

  off_t   read_head_r,    read_head_nxt;
  off_t   reserve_tail_r, reserve_tail_nxt;
  off_t   commit_tail_r,  commit_tail_nxt;
  logic   ok_r,           ok_nxt;
  field_t grant_r,        grant_nxt;
  field_t span_r,         span_nxt;

  off_t   used;
  off_t   avail;
  off_t   span_off;
  logic   len_nonzero;
  logic   fits;
  logic   start_match;

  // Occupancy checks; offsets wrap by truncation.
  assign used        = reserve_tail_r - read_head_r;
  assign avail       = ~used;
  assign span_off    = commit_tail_r - read_head_r;
  assign len_nonzero = (in_length != '0);
  assign fits        = WIDE_W'(in_length) <= WIDE_W'(avail);
  assign start_match = WIDE_W'(in_start_offset) == WIDE_W'(commit_tail_r);

  // Operation decode and pointer updates.
  always_comb begin
    read_head_nxt    = read_head_r;
    reserve_tail_nxt = reserve_tail_r;
    commit_tail_nxt  = commit_tail_r;
    ok_nxt           = 1'b0;
    grant_nxt        = '0;
    span_nxt         = '0;
    unique case (in_kind)
      KIND_ACQUIRE: begin
        if (len_nonzero && fits) begin
          ok_nxt           = 1'b1;
          grant_nxt        = off_to_field(reserve_tail_r);
          reserve_tail_nxt = reserve_tail_r + OFF_W'(in_length);
        end
      end
      KIND_RELEASE: begin
        if (len_nonzero && start_match) begin
          ok_nxt          = 1'b1;
          commit_tail_nxt = commit_tail_r + OFF_W'(in_length);
        end
      end
      KIND_CONSUME: begin
        if (read_head_r != commit_tail_r) begin
          ok_nxt        = 1'b1;
          grant_nxt     = off_to_field(read_head_r);
          span_nxt      = off_to_field(span_off);
          read_head_nxt = commit_tail_r;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Pointer registers, updated only for an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_head_r    <= '0;
      reserve_tail_r <= '0;
      commit_tail_r  <= '0;
    end else if (cmd.exec) begin
      read_head_r    <= read_head_nxt;
      reserve_tail_r <= reserve_tail_nxt;
      commit_tail_r  <= commit_tail_nxt;
    end
  end

  // Result register; its valid flag lives in the controller.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r    <= ok_nxt;
      grant_r <= grant_nxt;
      span_r  <= span_nxt;
    end
  end

  assign out_ok           = ok_r;
  assign out_grant_offset = grant_r;
  assign out_span_length  = span_r;

  // Pointers move only when a beat is executed.
  `ASSERT_IMPL(a_ptr_hold, !cmd.exec,
    $stable(read_head_r) && $stable(reserve_tail_r) && $stable(commit_tail_r),
    "ring pointers changed without an accepted beat")

  // After any consume the ring is drained up to the commit tail.
  `ASSERT_IMPL(a_consume_drains, cmd.exec && in_kind == KIND_CONSUME,
    read_head_r == commit_tail_r, "consume left committed bytes behind")

  // A zero length acquire or release is always refused.
  `ASSERT_IMPL(a_zero_len_refused,
    cmd.exec && !len_nonzero && (in_kind == KIND_ACQUIRE || in_kind == KIND_RELEASE),
    !ok_r, "zero length operation was granted")

endmodule

### sv/ring_reserve_commit_pointers.sv
// Result: the result beat is registered and shows on the output in the cycle
// after its operation beat is accepted.
// Throughput: one operation per cycle unless out_tready stalls; a beat is
// taken in the same cycle the held result leaves the single result register.
// Reset: rst_n low clears read head, reserve tail and commit tail to zero and
// empties the result register.
// ----------------------------------------------------------------------------
// ring_reserve_commit_pointers
// Pointer manager for a multi-producer, single-consumer byte ring with
// acquire, release-commit and consume operations.
// ----------------------------------------------------------------------------
module ring_reserve_commit_pointers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] length, [23:12] start_offset
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] grant_offset, [23:12] span_length
  output logic        out_tuser   // [0] ok
);
  import rrcp_pkg::*;

  rrcp_cmd_t cmd;
  kind_t     kind;
  field_t    grant_offset;
  field_t    span_length;

  assign kind = kind_t'(in_tuser);

  rrcp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rrcp_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (kind),
    .in_length        (in_tdata[FIELD_W-1:0]),
    .in_start_offset  (in_tdata[2*FIELD_W-1:FIELD_W]),
    .out_ok           (out_tuser),
    .out_grant_offset (grant_offset),
    .out_span_length  (span_length)
  );

  // Result beat packing.
  assign out_tdata = {span_length, grant_offset};

endmodule

### tb/ring_pointer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_pointer_checker
// Watches the operation and result channels of the ring pointer manager,
// tracks read head, reserve tail and commit tail of its own, and compares
// every result beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ring_pointer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] length, [23:12] start_offset
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [11:0] grant_offset, [23:12] span_length
  input  logic        out_tuser,  // [0] ok
  output int          fail_count,
  output int          pending
);
  import rrcp_pkg::*;

  typedef struct packed {
    logic   ok;
    field_t grant_offset;
    field_t span_length;
  } ring_result_t;

  // Pointer copies, kept as plain integers modulo the ring size.
  int head_ptr;
  int reserve_ptr;
  int commit_ptr;

  ring_result_t owed_results[$];
  ring_result_t seen;
  ring_result_t oldest;
  int           mismatches = 0;

  // Distance from one ring offset forward to another.
  function automatic int ring_gap(int to_off, int from_off);
    return (to_off + RING_BYTES - from_off) % RING_BYTES;
  endfunction

  // Apply one operation to the pointer copies and return its result.
  function automatic ring_result_t apply_op(kind_t kind, field_t len, field_t start);
    ring_result_t res;
    int           room;
    res = '0;
    case (kind)
      KIND_ACQUIRE: begin
        room = RING_BYTES - 1 - ring_gap(reserve_ptr, head_ptr);
        if (len != '0 && int'(len) <= room) begin
          res.ok           = 1'b1;
          res.grant_offset = field_t'(reserve_ptr);
          reserve_ptr      = (reserve_ptr + int'(len)) % RING_BYTES;
        end
      end
      KIND_RELEASE: begin
        // The region is not checked against the reservation.
        if (len != '0 && int'(start) == commit_ptr) begin
          res.ok     = 1'b1;
          commit_ptr = (int'(start) + int'(len)) % RING_BYTES;
        end
      end
      KIND_CONSUME: begin
        if (head_ptr != commit_ptr) begin
          res.ok           = 1'b1;
          res.grant_offset = field_t'(head_ptr);
          res.span_length  = field_t'(ring_gap(commit_ptr, head_ptr));
          head_ptr         = commit_ptr;
        end
      end
      default: begin
        // The unused kind changes nothing and reports a refusal.
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Compare first, then predict: a result never belongs to the beat
  // accepted on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      head_ptr    = 0;
      reserve_ptr = 0;
      commit_ptr  = 0;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.ok           = out_tuser;
        seen.grant_offset = out_tdata[FIELD_W-1:0];
        seen.span_length  = out_tdata[2*FIELD_W-1:FIELD_W];
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with no operation outstanding");
        end else begin
          oldest = owed_results.pop_front();
          if (seen.ok !== oldest.ok)
            report_mismatch($sformatf("ok %0b, predicted %0b", seen.ok, oldest.ok));
          if (seen.grant_offset !== oldest.grant_offset)
            report_mismatch($sformatf("grant_offset %0d, predicted %0d",
                                      seen.grant_offset, oldest.grant_offset));
          if (seen.span_length !== oldest.span_length)
            report_mismatch($sformatf("span_length %0d, predicted %0d",
                                      seen.span_length, oldest.span_length));
        end
      end
      if (in_tvalid && in_tready) begin
        owed_results.push_back(apply_op(kind_t'(in_tuser), in_tdata[FIELD_W-1:0],
                                        in_tdata[2*FIELD_W-1:FIELD_W]));
      end
    end
    pending    <= owed_results.size();
    fail_count <= mismatches;
  end

endmodule

### tb/ring_reserve_commit_pointers_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_reserve_commit_pointers_tb
// Drives acquire, release and consume operations into the ring pointer
// manager: a directed opening over the edge cases, then producer-like
// sequences that release their own reservations in order, mixed with
// out-of-order releases and random noise, under three idling profiles.
// ----------------------------------------------------------------------------
module ring_reserve_commit_pointers_tb;
  import rrcp_pkg::*;

  localparam int PH_SLOW_RX = 0;
  localparam int PH_SLOW_TX = 1;
  localparam int PH_FREE    = 2;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    field_t start;
    field_t len;
  } region_t;

  typedef struct {
    kind_t  kind;
    field_t len;
    field_t start;
    bit     track;
    bit     in_order;
  } issued_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [11:0] length, [23:12] start_offset
  logic [1:0]  in_tuser   = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [11:0] grant_offset, [23:12] span_length
  logic        out_tuser;         // [0] ok

  int          fail_count;
  int          pending;
  int          phase      = PH_SLOW_RX;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;

  // Producer view, built from the result beats as they come back.
  region_t     open_regions[$];
  issued_t     issued_log[$];
  int          seen_commit = 0;
  bit          release_busy = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ring_reserve_commit_pointers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ring_pointer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls by phase, plus one long hold-off at the
  // start of the free-running phase so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (phase == PH_FREE && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (phase == PH_SLOW_RX) begin
      out_tready <= ($urandom_range(99) >= 88);
    end else if (phase == PH_SLOW_TX) begin
      out_tready <= ($urandom_range(99) >= 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Learn granted regions and the commit tail from the result beats.
  task automatic collect_results();
    issued_t rec;
    region_t reg_entry;
    if (rst_n && out_tvalid && out_tready && issued_log.size() > 0) begin
      rec = issued_log.pop_front();
      if (rec.kind == KIND_ACQUIRE && rec.track && out_tuser) begin
        reg_entry.start = out_tdata[FIELD_W-1:0];
        reg_entry.len   = rec.len;
        open_regions.push_back(reg_entry);
        if (open_regions.size() > 48)
          void'(open_regions.pop_front());
      end
      if (rec.kind == KIND_RELEASE) begin
        if (out_tuser) begin
          seen_commit = (int'(rec.start) + int'(rec.len)) % RING_BYTES;
          if (rec.in_order && open_regions.size() > 0)
            void'(open_regions.pop_front());
        end
        if (rec.in_order)
          release_busy = 1'b0;
      end
    end
  endtask

  // Offer one operation beat, hold it until taken, then idle at random.
  task automatic send_op(kind_t kind, field_t len, field_t start, bit track,
                         bit in_order, int idle_pct);
    issued_t rec;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {start, len};
    do begin
      @(posedge clk);
      collect_results();
    end while (!in_tready);
    rec.kind     = kind;
    rec.len      = len;
    rec.start    = start;
    rec.track    = track;
    rec.in_order = in_order;
    issued_log.push_back(rec);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      collect_results();
    end
  endtask

  // Random acquire length: mostly small, sometimes large, rarely zero.
  function automatic field_t pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return field_t'($urandom_range(200, 1));
    if (sel < 90) return field_t'($urandom_range(1200, 1));
    if (sel < 97) return field_t'($urandom_range(4095, 1200));
    return '0;
  endfunction

  // Producer-like traffic: in-order releases of granted regions, consumes,
  // out-of-order release attempts and a share of unstructured noise.
  task automatic run_random(int count, int idle_pct);
    int      sel;
    int      idx;
    int      gap;
    region_t oldest;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_op(KIND_ACQUIRE, pick_length(), field_t'($urandom), 1'b1, 1'b0, idle_pct);
      end else if (sel < 70 && open_regions.size() > 0) begin
        if ($urandom_range(99) < 85 && !release_busy) begin
          // Release from the commit tail up to the end of the oldest region;
          // this also pulls the commit tail back in line after noise.
          oldest = open_regions[0];
          gap = (int'(oldest.start) + int'(oldest.len) - seen_commit + 2 * RING_BYTES)
                % RING_BYTES;
          if (gap == 0) begin
            void'(open_regions.pop_front());
            send_op(KIND_CONSUME, '0, '0, 1'b0, 1'b0, idle_pct);
          end else begin
            release_busy = 1'b1;
            send_op(KIND_RELEASE, field_t'(gap), field_t'(seen_commit), 1'b0, 1'b1,
                    idle_pct);
          end
        end else begin
          // A random open region released out of turn, normally refused.
          idx = $urandom_range(open_regions.size() - 1, 0);
          send_op(KIND_RELEASE, open_regions[idx].len, open_regions[idx].start,
                  1'b0, 1'b0, idle_pct);
        end
      end else if (sel < 88) begin
        send_op(KIND_CONSUME, field_t'($urandom), field_t'($urandom), 1'b0, 1'b0, idle_pct);
      end else begin
        send_op(kind_t'($urandom_range(3, 0)), field_t'($urandom), field_t'($urandom),
                1'b0, 1'b0, idle_pct);
      end
    end
  endtask

  // Directed opening: empty ring, zero lengths, the unused kind, a full
  // ring, wrap-around of every pointer, a release at a wrong start and
  // releases that run past the reservation.
  task automatic run_directed();
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_UNUSED,  12'hFFF,  12'hFFF,  1'b0, 1'b0, 8);
    send_op(KIND_UNUSED,  '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, 12'd4095, 12'hFFF,  1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, 12'd1,    '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd10,   12'd1,    1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd4095, 12'd0,    1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, 12'hFFF,  12'hFFF,  1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, 12'd4095, '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd100,  12'd4095, 1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd4095, 12'd99,   1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, 12'd1,    '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd1,    12'd4095, 1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd3997, 12'd98,   1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
    send_op(KIND_ACQUIRE, 12'd1,    '0,       1'b0, 1'b0, 8);
    send_op(KIND_RELEASE, 12'd1,    12'd4095, 1'b0, 1'b0, 8);
    send_op(KIND_CONSUME, '0,       '0,       1'b0, 1'b0, 8);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(600, 8);
    phase <= PH_SLOW_TX;
    run_random(600, 88);
    phase <= PH_FREE;
    run_random(550, 0);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
